/* sv/mase_pkg.sv */
package mase_pkg;

   localparam int MAX_DIM_DEF = 8;
   localparam int ELEM_WIDTH_DEF = 16;

   localparam int FUNC_W = 2;
   localparam int POS_W = 3;
   localparam int VALUE_W = 16;
   localparam int OP_W = 2;
   localparam int RES_W = 40;
   localparam int CSR_W = 4;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_A    = 2'd0,
      FUNC_WR_B    = 2'd1,
      FUNC_COMPUTE = 2'd2
   } func_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_SUB  = 2'd1,
      OP_RSUB = 2'd2,
      OP_MUL  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A = 2'd0,
      CSR_COLS_A = 2'd1,
      CSR_ROWS_B = 2'd2,
      CSR_COLS_B = 2'd3
   } csr_type;

   typedef struct packed {
      logic   term_en;
      logic   acc_en;
      logic   acc_clr;
      op_type op;
   } mac_ctl_type;

endpackage

/* sv/mase_mac.sv */
module mase_mac #(
   parameter int ELEM_WIDTH = mase_pkg::ELEM_WIDTH_DEF
) (
   input  logic                               clock,
   input  mase_pkg::mac_ctl_type              ctl,
   input  logic signed [ELEM_WIDTH-1:0]       opa,
   input  logic signed [ELEM_WIDTH-1:0]       opb,
   output logic signed [mase_pkg::RES_W-1:0]  acc
);
   import mase_pkg::*;

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int WIDE_W = (PROD_W > RES_W) ? PROD_W : RES_W;

   logic signed [PROD_W-1:0] prod;
   logic signed [WIDE_W-1:0] prod_wide;
   logic signed [RES_W-1:0]  term_in;
   logic signed [RES_W-1:0]  term_ff;
   logic signed [RES_W-1:0]  acc_in;
   logic signed [RES_W-1:0]  acc_ff;

   always_comb begin
      prod      = opa * opb;
      prod_wide = WIDE_W'(prod);
      unique case (ctl.op)
         OP_ADD:  term_in = RES_W'(opa) + RES_W'(opb);
         OP_SUB:  term_in = RES_W'(opa) - RES_W'(opb);
         OP_RSUB: term_in = RES_W'(opb) - RES_W'(opa);
         OP_MUL:  term_in = prod_wide[RES_W-1:0];
         default: term_in = '0;
      endcase
      acc_in = ctl.acc_clr ? term_ff : acc_ff + term_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.term_en) begin
         term_ff <= term_in;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* sv/matrix_add_sub_mul_engine.sv */
// Matrix engine: req items with func write-A / write-B store one element (no result),
// and a compute item runs A+B, A-B, B-A or A*B over the shapes in the csr registers,
// returning every result element row-major with last on the final one, or a single
// dim_error item on a shape mismatch. All arithmetic goes through one shared
// multiply/add-accumulate unit fed by one read port per store: each multiply term
// passes the read, multiply and accumulate steps, a sum or difference element passes
// them once, and each element then waits in an output step for a free rsp register.
// A mismatch answer waits likewise in an error step. req_ready is low while a compute
// runs; write items are taken while the final result still waits in the rsp register.
module matrix_add_sub_mul_engine #(
   parameter int MAX_DIM    = mase_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mase_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_we,
   input  logic [mase_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mase_pkg::CSR_W-1:0]           csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mase_pkg::FUNC_W-1:0]          req_func,
   input  logic [mase_pkg::POS_W-1:0]           req_row,
   input  logic [mase_pkg::POS_W-1:0]           req_col,
   input  logic signed [mase_pkg::VALUE_W-1:0]  req_value,
   input  logic [mase_pkg::OP_W-1:0]            req_operation,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mase_pkg::POS_W-1:0]           rsp_out_row,
   output logic [mase_pkg::POS_W-1:0]           rsp_out_col,
   output logic signed [mase_pkg::RES_W-1:0]    rsp_result,
   output logic                                 rsp_dim_error,
   output logic                                 rsp_last
);
   import mase_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam logic [AW-1:0] STRIDE = AW'(MAX_DIM);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR,
      S_RD,
      S_MUL,
      S_ACC,
      S_OUT
   } state_type;

   function automatic logic [IDX_W-1:0] dim_m1(input logic [CSR_W-1:0] d);
      logic [CSR_W-1:0] dm;
      dm = d - CSR_W'(1);
      if (d == '0) begin
         return '0;
      end
      if (d > CSR_W'(MAX_DIM)) begin
         return IDX_W'(MAX_DIM - 1);
      end
      return dm[IDX_W-1:0];
   endfunction

   state_type             state_ff;
   op_type                op_ff;
   logic [IDX_W-1:0]      i_ff, j_ff, k_ff;
   logic [CSR_W-1:0]      rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic                  rsp_valid_ff;
   logic [POS_W-1:0]      out_row_ff, out_col_ff;
   logic signed [RES_W-1:0] result_ff;
   logic                  dim_error_ff, last_ff;

   logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
   logic signed [ELEM_WIDTH-1:0] rd_a_ff, rd_b_ff;

   logic [IDX_W-1:0]      ra_m1, ca_m1, rb_m1, cb_m1, j_end;
   logic                  mismatch, out_free, in_range, wr_a, wr_b, req_fire;
   logic [AW-1:0]         wr_addr, rd_addr_a, rd_addr_b;
   logic signed [ELEM_WIDTH-1:0] wr_data;
   op_type                req_op;
   func_type              req_fn;
   mac_ctl_type           mac_ctl;
   logic signed [RES_W-1:0] mac_acc;

   always_comb begin
      ra_m1    = dim_m1(rows_a_ff);
      ca_m1    = dim_m1(cols_a_ff);
      rb_m1    = dim_m1(rows_b_ff);
      cb_m1    = dim_m1(cols_b_ff);
      req_op   = op_type'(req_operation);
      req_fn   = func_type'(req_func);
      mismatch = (req_op == OP_MUL) ? (ca_m1 != rb_m1)
                                    : ((ra_m1 != rb_m1) || (ca_m1 != cb_m1));
      j_end    = (op_ff == OP_MUL) ? cb_m1 : ca_m1;
      out_free = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == S_IDLE);
      req_fire  = req_valid && req_ready;

      in_range = ({1'b0, req_row} < (POS_W + 1)'(MAX_DIM)) &&
                 ({1'b0, req_col} < (POS_W + 1)'(MAX_DIM));
      wr_addr  = AW'(req_row) * STRIDE + AW'(req_col);
      wr_data  = ELEM_WIDTH'(req_value);
      wr_a     = req_fire && in_range && (req_fn == FUNC_WR_A);
      wr_b     = req_fire && in_range && (req_fn == FUNC_WR_B);

      if (op_ff == OP_MUL) begin
         rd_addr_a = AW'(i_ff) * STRIDE + AW'(k_ff);
         rd_addr_b = AW'(k_ff) * STRIDE + AW'(j_ff);
      end else begin
         rd_addr_a = AW'(i_ff) * STRIDE + AW'(j_ff);
         rd_addr_b = rd_addr_a;
      end

      mac_ctl.term_en = (state_ff == S_MUL);
      mac_ctl.acc_en  = (state_ff == S_ACC);
      mac_ctl.acc_clr = (op_ff != OP_MUL) || (k_ff == '0);
      mac_ctl.op      = op_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (wr_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_a[rd_addr_a];
      rd_b_ff <= mem_b[rd_addr_b];
   end

   mase_mac #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .opa   (rd_a_ff),
      .opb   (rd_b_ff),
      .acc   (mac_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ADD;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rows_a_ff    <= CSR_W'(1);
         cols_a_ff    <= CSR_W'(1);
         rows_b_ff    <= CSR_W'(1);
         cols_b_ff    <= CSR_W'(1);
      end else begin
         if (csr_we) begin
            unique case (csr_type'(csr_index))
               CSR_ROWS_A: rows_a_ff <= csr_wdata;
               CSR_COLS_A: cols_a_ff <= csr_wdata;
               CSR_ROWS_B: rows_b_ff <= csr_wdata;
               CSR_COLS_B: cols_b_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_ready && (state_ff != S_ERR) && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_fn == FUNC_COMPUTE)) begin
                  op_ff    <= req_op;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= mismatch ? S_ERR : S_RD;
               end
            end
            S_ERR: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_row_ff   <= '0;
                  out_col_ff   <= '0;
                  result_ff    <= '0;
                  dim_error_ff <= 1'b1;
                  last_ff      <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_RD: begin
               state_ff <= S_MUL;
            end
            S_MUL: begin
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if ((op_ff != OP_MUL) || (k_ff == ca_m1)) begin
                  state_ff <= S_OUT;
               end else begin
                  k_ff     <= k_ff + IDX_W'(1);
                  state_ff <= S_RD;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_row_ff   <= POS_W'(i_ff);
                  out_col_ff   <= POS_W'(j_ff);
                  result_ff    <= mac_acc;
                  dim_error_ff <= 1'b0;
                  last_ff      <= (i_ff == ra_m1) && (j_ff == j_end);
                  k_ff         <= '0;
                  state_ff     <= S_RD;
                  if (j_ff == j_end) begin
                     j_ff <= '0;
                     if (i_ff == ra_m1) begin
                        state_ff <= S_IDLE;
                     end else begin
                        i_ff <= i_ff + IDX_W'(1);
                     end
                  end else begin
                     j_ff <= j_ff + IDX_W'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_result    = result_ff;
   assign rsp_dim_error = dim_error_ff;
   assign rsp_last      = last_ff;

endmodule

/* test/testbench.sv */
module testbench;
   import mase_pkg::*;

   localparam int MAX_DIM = MAX_DIM_DEF;
   localparam int CELLS = MAX_DIM * MAX_DIM;
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
   localparam int ITEM_GOAL = 270;
   localparam int QUIET_AT = 235;
   localparam int SETTLE = 8;
   localparam int CHOKE_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [POS_W-1:0]          row;
      logic [POS_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
      op_type                    op;
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [RES_W-1:0] result;
      logic                    err;
      logic                    last;
   } elem_type;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      cmd_type                 cmd;
      csr_type                 idx;
      logic [CSR_W-1:0]        wdata;
      logic                    typed;
      logic signed [RES_W-1:0] x_result;
      logic                    x_err;
   } plan_row_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_W-1:0]             csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [FUNC_W-1:0]            req_func = '0;
   logic [POS_W-1:0]             req_row = '0;
   logic [POS_W-1:0]             req_col = '0;
   logic signed [VALUE_W-1:0]    req_value = '0;
   logic [OP_W-1:0]              req_operation = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [POS_W-1:0]             rsp_out_row;
   logic [POS_W-1:0]             rsp_out_col;
   logic signed [RES_W-1:0]      rsp_result;
   logic                         rsp_dim_error;
   logic                         rsp_last;

   logic signed [VALUE_W-1:0] store_a [CELLS];
   logic signed [VALUE_W-1:0] store_b [CELLS];
   bit                        loaded_a [CELLS];
   bit                        loaded_b [CELLS];
   logic [CSR_W-1:0]          dim_reg [4];
   elem_type                  pending_elems [$];
   elem_type                  got, want;
   int                        mismatches = 0;
   int                        items_sent = 0;
   int                        cycles = 0;
   int                        gap_rate = 3;
   int                        stall_rate = 3;
   bit                        quiet = 1'b0;
   bit                        choke_req = 1'b0;

   matrix_add_sub_mul_engine dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_dim(input logic [CSR_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   function automatic void matrix_predict(input cmd_type c);
      int ra, ca, rb, cb, ncol, i, j, k;
      longint acc, a, b;
      elem_type e;
      ra = eff_dim(dim_reg[CSR_ROWS_A]);
      ca = eff_dim(dim_reg[CSR_COLS_A]);
      rb = eff_dim(dim_reg[CSR_ROWS_B]);
      cb = eff_dim(dim_reg[CSR_COLS_B]);
      e = '0;
      case (c.func)
         FUNC_WR_A: begin
            store_a[c.row * MAX_DIM + c.col] = c.value;
            loaded_a[c.row * MAX_DIM + c.col] = 1'b1;
         end
         FUNC_WR_B: begin
            store_b[c.row * MAX_DIM + c.col] = c.value;
            loaded_b[c.row * MAX_DIM + c.col] = 1'b1;
         end
         FUNC_COMPUTE: begin
            if ((c.op == OP_MUL) ? (ca != rb) : (ra != rb || ca != cb)) begin
               e.err = 1'b1;
               e.last = 1'b1;
               pending_elems.push_back(e);
            end else begin
               ncol = (c.op == OP_MUL) ? cb : ca;
               for (i = 0; i < ra; i++) begin
                  for (j = 0; j < ncol; j++) begin
                     acc = 0;
                     if (c.op == OP_MUL) begin
                        for (k = 0; k < ca; k++)
                           acc += longint'(store_a[i * MAX_DIM + k]) *
                                  longint'(store_b[k * MAX_DIM + j]);
                     end else begin
                        a = longint'(store_a[i * MAX_DIM + j]);
                        b = longint'(store_b[i * MAX_DIM + j]);
                        case (c.op)
                           OP_ADD:  acc = a + b;
                           OP_SUB:  acc = a - b;
                           default: acc = b - a;
                        endcase
                     end
                     e.row = i[POS_W-1:0];
                     e.col = j[POS_W-1:0];
                     e.result = acc[RES_W-1:0];
                     e.last = (i == ra - 1 && j == ncol - 1);
                     pending_elems.push_back(e);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic plan_row_type ld(input logic [FUNC_W-1:0] f, input int r, input int c,
                                       input int v);
      plan_row_type p;
      p = '0;
      p.kind = STEP_ITEM;
      p.cmd.func = f;
      p.cmd.row = r[POS_W-1:0];
      p.cmd.col = c[POS_W-1:0];
      p.cmd.value = v[VALUE_W-1:0];
      p.cmd.op = op_type'($urandom_range(0, 3));
      return p;
   endfunction

   function automatic plan_row_type calc(input op_type op);
      plan_row_type p;
      p = '0;
      p.kind = STEP_ITEM;
      p.cmd.func = FUNC_COMPUTE;
      p.cmd.row = 3'($urandom_range(0, 7));
      p.cmd.col = 3'($urandom_range(0, 7));
      p.cmd.value = 16'($urandom);
      p.cmd.op = op;
      return p;
   endfunction

   function automatic plan_row_type calc_x(input op_type op, input longint res,
                                           input bit err);
      plan_row_type p;
      p = calc(op);
      p.typed = 1'b1;
      p.x_result = res[RES_W-1:0];
      p.x_err = err;
      return p;
   endfunction

   function automatic plan_row_type csr_set(input csr_type idx, input int v);
      plan_row_type p;
      p = '0;
      p.kind = STEP_CSR;
      p.idx = idx;
      p.wdata = v[CSR_W-1:0];
      return p;
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return -16'sd1;
         3:       return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 39);
      if (r == 0) return 4'd0;
      if (r == 1) return 4'($urandom_range(8, 15));
      return 4'($urandom_range(1, 4));
   endfunction

   function automatic int pick_rate();
      int r;
      r = $urandom_range(0, 3);
      return (r == 0) ? 0 : r + 1;
   endfunction

   task automatic send_item(input cmd_type c);
      if (!quiet && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= c.func;
      req_row <= c.row;
      req_col <= c.col;
      req_value <= c.value;
      req_operation <= c.op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (c.func != FUNC_NONE) items_sent++;
   endtask

   task automatic issue(input cmd_type c);
      send_item(c);
      matrix_predict(c);
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [CSR_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      dim_reg[idx] = v;
   endtask

   // occasional ignored or off-shape item between element loads
   task automatic stray_item();
      cmd_type c;
      if ($urandom_range(0, 9) != 0) return;
      c.row = 3'($urandom_range(0, 7));
      c.col = 3'($urandom_range(0, 7));
      c.value = rand_value();
      c.op = op_type'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) c.func = FUNC_NONE;
      else c.func = $urandom_range(0, 1) ? FUNC_WR_A : FUNC_WR_B;
      issue(c);
   endtask

   // loads A and B over the current shapes; never-written cells are always loaded
   task automatic load_operands(input bit all);
      int ra, ca, rb, cb, i, j;
      cmd_type c;
      ra = eff_dim(dim_reg[CSR_ROWS_A]);
      ca = eff_dim(dim_reg[CSR_COLS_A]);
      rb = eff_dim(dim_reg[CSR_ROWS_B]);
      cb = eff_dim(dim_reg[CSR_COLS_B]);
      for (i = 0; i < ra; i++) begin
         for (j = 0; j < ca; j++) begin
            if (all || !loaded_a[i * MAX_DIM + j] || $urandom_range(0, 1)) begin
               c.func = FUNC_WR_A;
               c.row = i[POS_W-1:0];
               c.col = j[POS_W-1:0];
               c.value = rand_value();
               c.op = op_type'($urandom_range(0, 3));
               issue(c);
               stray_item();
            end
         end
      end
      for (i = 0; i < rb; i++) begin
         for (j = 0; j < cb; j++) begin
            if (all || !loaded_b[i * MAX_DIM + j] || $urandom_range(0, 1)) begin
               c.func = FUNC_WR_B;
               c.row = i[POS_W-1:0];
               c.col = j[POS_W-1:0];
               c.value = rand_value();
               c.op = op_type'($urandom_range(0, 3));
               issue(c);
               stray_item();
            end
         end
      end
   endtask

   initial begin : stimulus
      plan_row_type plan [$];
      cmd_type c;
      elem_type e;
      op_type plan_op;
      bit well;
      logic [CSR_W-1:0] dims [4];
      int ncomp, phase, k;

      foreach (dim_reg[i]) dim_reg[i] = 4'd1;
      plan = '{
         ld(FUNC_WR_A, 0, 0, 32767),
         ld(FUNC_WR_B, 0, 0, 32767),
         calc_x(OP_ADD, 65534, 0),
         calc_x(OP_SUB, 0, 0),
         ld(FUNC_WR_B, 0, 0, -32768),
         calc_x(OP_SUB, 65535, 0),
         calc_x(OP_RSUB, -65535, 0),
         calc_x(OP_MUL, -1073709056, 0),
         ld(FUNC_WR_A, 0, 0, -32768),
         calc_x(OP_MUL, 1073741824, 0),
         calc_x(OP_ADD, -65536, 0),
         ld(FUNC_NONE, 7, 7, -1),
         ld(FUNC_WR_A, 7, 7, 32767),
         ld(FUNC_WR_B, 7, 7, -1),
         csr_set(CSR_ROWS_A, 0),
         csr_set(CSR_COLS_A, 15),
         calc_x(OP_ADD, 0, 1),
         calc_x(OP_MUL, 0, 1),
         csr_set(CSR_ROWS_B, 9),
         calc_x(OP_RSUB, 0, 1),
         csr_set(CSR_COLS_B, 0),
         calc_x(OP_SUB, 0, 1),
         csr_set(CSR_ROWS_A, 1),
         csr_set(CSR_COLS_A, 1),
         csr_set(CSR_ROWS_B, 1),
         csr_set(CSR_COLS_B, 1),
         calc(OP_RSUB),
         ld(FUNC_WR_A, 0, 0, 12345),
         calc(OP_MUL)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         if (plan[n].kind == STEP_CSR) begin
            drain_idle();
            write_csr(plan[n].idx, plan[n].wdata);
            csr_we <= 1'b0;
         end else begin
            send_item(plan[n].cmd);
            if (plan[n].typed) begin
               e = '0;
               e.result = plan[n].x_result;
               e.err = plan[n].x_err;
               e.last = 1'b1;
               pending_elems.push_back(e);
            end else begin
               matrix_predict(plan[n].cmd);
            end
         end
      end

      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         drain_idle();
         quiet = (items_sent >= QUIET_AT);
         gap_rate = quiet ? 0 : pick_rate();
         stall_rate = quiet ? 0 : pick_rate();
         plan_op = op_type'($urandom_range(0, 3));
         well = (phase == 2) || ($urandom_range(0, 9) < 8);
         foreach (dims[i]) dims[i] = pick_dim();
         if (well) begin
            if (plan_op == OP_MUL) begin
               dims[CSR_ROWS_B] = dims[CSR_COLS_A];
            end else begin
               dims[CSR_ROWS_B] = dims[CSR_ROWS_A];
               dims[CSR_COLS_B] = dims[CSR_COLS_A];
            end
         end
         foreach (dims[i]) write_csr(csr_type'(i), dims[i]);
         csr_we <= 1'b0;
         ncomp = (phase == 2) ? 2 : $urandom_range(1, 3);
         for (k = 0; k < ncomp; k++) begin
            load_operands(k == 0);
            c.func = FUNC_COMPUTE;
            c.row = 3'($urandom_range(0, 7));
            c.col = 3'($urandom_range(0, 7));
            c.value = 16'($urandom);
            c.op = (k == 0) ? plan_op : op_type'($urandom_range(0, 3));
            // long rsp hold-off while the next items are offered
            if (phase == 2 && k == 0) choke_req = 1'b1;
            issue(c);
         end
         phase++;
      end

      drain_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_elems.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (choke_req) begin
            choke_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && stall_rate != 0 && $urandom_range(1, stall_rate * 2) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.row = rsp_out_row;
         got.col = rsp_out_col;
         got.result = rsp_result;
         got.err = rsp_dim_error;
         got.last = rsp_last;
         if (pending_elems.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item row %0d col %0d result %0d err %0b last %0b",
                     $time, got.row, got.col, got.result, got.err, got.last);
         end else begin
            want = pending_elems.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: expected row %0d col %0d result %0d err %0b last %0b",
                        $time, want.row, want.col, want.result, want.err, want.last);
               $display("%0t:   actual row %0d col %0d result %0d err %0b last %0b",
                        $time, got.row, got.col, got.result, got.err, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
